### design/mgw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgw_pkg
// Shared types and constants for the maze generate-and-walk unit.
// ----------------------------------------------------------------------------
package mgw_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 16;
    localparam int XW          = 5;
    localparam int YW          = 4;
    localparam int AW          = 9;
    localparam int DEPTH       = 512;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

    localparam logic [3:0]  WALL_N    = 4'd1;
    localparam logic [3:0]  WALL_E    = 4'd2;
    localparam logic [3:0]  WALL_S    = 4'd4;
    localparam logic [3:0]  WALL_W    = 4'd8;
    localparam logic [3:0]  WALL_ALL  = 4'd15;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] OP_GEN  = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef struct packed {
        logic [1:0]    op;
        logic [XW-1:0] cell_x;
        logic [YW-1:0] cell_y;
        logic [1:0]    direction;
    } req_t;

    typedef struct packed {
        logic [3:0]    walls;
        logic [XW-1:0] player_col;
        logic [YW-1:0] player_row;
        logic          moved;
        logic          at_goal;
        logic [15:0]   move_total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TOP,
        ST_NREQ,
        ST_NWAIT,
        ST_DECIDE,
        ST_CARVE,
        ST_MOVE,
        ST_READ,
        ST_DONE
    } state_t;

    function automatic logic [3:0] wall_here(input logic [1:0] d);
        case (d)
            DIR_N:   wall_here = WALL_N;
            DIR_E:   wall_here = WALL_E;
            DIR_S:   wall_here = WALL_S;
            default: wall_here = WALL_W;
        endcase
    endfunction

    function automatic logic [3:0] wall_there(input logic [1:0] d);
        case (d)
            DIR_N:   wall_there = WALL_S;
            DIR_E:   wall_there = WALL_W;
            DIR_S:   wall_there = WALL_N;
            default: wall_there = WALL_E;
        endcase
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        lfsr_next = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

### design/mgw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgw_req_if / mgw_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface mgw_req_if import mgw_pkg::*;;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mgw_rsp_if import mgw_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/mgw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgw_ram
// Generic single-write, single-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mgw_ram #(
    parameter int W  = 4,
    parameter int AW = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/maze_generate_and_walk_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_generate_and_walk_unit
// Generate: a clear pass over the cell RAM, then carve steps and backtracks,
//   with neighbor probes done one at a time on the single cell RAM read port.
// Move and read: the response is registered; one transaction at a time.
// Reset clears control state and runs one clear pass before the
// first request is taken.
// ----------------------------------------------------------------------------
module maze_generate_and_walk_unit import mgw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    mgw_req_if.sink     req,
    mgw_rsp_if.source   rsp
);
    // cell RAM word: {visited, walls}
    logic          cw_we;
    logic [AW-1:0] cw_waddr, cw_raddr;
    logic [4:0]    cw_wdata, cw_rdata;
    logic          sk_we;
    logic [AW-1:0] sk_waddr, sk_raddr;
    logic [AW-1:0] sk_wdata, sk_rdata;

    mgw_ram #(.W(5), .AW(AW)) u_cell (
        .clk(clk), .we(cw_we), .waddr(cw_waddr), .wdata(cw_wdata),
        .raddr(cw_raddr), .rdata(cw_rdata)
    );
    mgw_ram #(.W(AW), .AW(AW)) u_stack (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata)
    );

    state_t        state_reg, state_next;
    logic [15:0]   seed_reg;
    logic [15:0]   lfsr_reg, lfsr_next_v;
    logic [AW:0]   sp_reg, sp_next;
    logic [AW:0]   clr_reg, clr_next;
    logic          gen_reg, gen_next;
    req_t          req_reg, req_next;
    logic [XW-1:0] px_reg, px_next, cx_reg, cx_next;
    logic [YW-1:0] py_reg, py_next, cy_reg, cy_next;
    logic [15:0]   mc_reg, mc_next;
    logic [1:0]    nd_reg, nd_next;
    logic [3:0]    opt_reg, opt_next;
    logic [3:0]    cwall_reg, cwall_next;
    logic [1:0]    dsel_reg, dsel_next;
    logic          carved_reg, carved_next;
    rsp_t          out_reg, out_next;
    logic          ov_reg, ov_next;

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          nin;
    logic [2:0]    cnt;
    logic [1:0]    pick;
    logic [1:0]    k;
    logic [15:0]   lv;
    logic [15:0]   q3;

    function automatic logic [AW-1:0] idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
        idx = AW'((32'(y) * GRID_WIDTH + 32'(x)) % DEPTH);
    endfunction

    always_comb
    begin
        sx = (32'(req.data.cell_x) >= GRID_WIDTH) ? XW'(GRID_WIDTH - 1) : req.data.cell_x;
        sy = (32'(req.data.cell_y) >= GRID_HEIGHT) ? YW'(GRID_HEIGHT - 1) : req.data.cell_y;
    end

    // neighbor of (cx,cy) in direction nd_reg
    always_comb
    begin
        nx  = cx_reg;
        ny  = cy_reg;
        nin = 1'b1;
        case (nd_reg)
            DIR_N:
            begin
                nin = (cy_reg != '0);
                ny  = cy_reg - 1'b1;
            end
            DIR_E:
            begin
                nin = (32'(cx_reg) < GRID_WIDTH - 1);
                nx  = cx_reg + 1'b1;
            end
            DIR_S:
            begin
                nin = (32'(cy_reg) < GRID_HEIGHT - 1);
                ny  = cy_reg + 1'b1;
            end
            default:
            begin
                nin = (cx_reg != '0);
                nx  = cx_reg - 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt  = 3'(opt_reg[0]) + 3'(opt_reg[1]) + 3'(opt_reg[2]) + 3'(opt_reg[3]);
        lv   = lfsr_next(lfsr_reg);
        // lv / 3 by reciprocal multiplication, exact over 16 bits
        q3   = 16'((32'(lv) * 32'd43691) >> 17);
        case (cnt)
            3'd1:    k = 2'd0;
            3'd2:    k = 2'(lv % 2);
            3'd3:    k = 2'(lv - 16'(q3 * 16'd3));
            default: k = 2'(lv % 4);
        endcase
        pick = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (opt_reg[i] && (3'(opt_reg[0] & (i > 0)) + 3'(opt_reg[1] & (i > 1))
                + 3'(opt_reg[2] & (i > 2))) == 3'(k))
            begin
                pick = 2'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        lfsr_next_v = lfsr_reg;
        sp_next     = sp_reg;
        clr_next    = clr_reg;
        gen_next    = gen_reg;
        req_next    = req_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        mc_next     = mc_reg;
        nd_next     = nd_reg;
        opt_next    = opt_reg;
        cwall_next  = cwall_reg;
        dsel_next   = dsel_reg;
        carved_next = carved_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        cw_we       = 1'b0;
        cw_waddr    = idx(cx_reg, cy_reg);
        cw_wdata    = {1'b0, WALL_ALL};
        cw_raddr    = idx(cx_reg, cy_reg);
        sk_we       = 1'b0;
        sk_waddr    = sp_reg[AW-1:0];
        sk_wdata    = idx(cx_reg, cy_reg);
        sk_raddr    = AW'(sp_reg - 1'b1);
        req.ready   = 1'b0;
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = !ov_reg;
                cw_raddr  = idx(px_reg, py_reg);
                if (req.valid && !ov_reg)
                begin
                    req_next = req.data;
                    cx_next  = sx;
                    cy_next  = sy;
                    case (req.data.op)
                        OP_GEN:
                        begin
                            clr_next   = '0;
                            gen_next   = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        OP_MOVE: state_next = ST_MOVE;
                        OP_READ:
                        begin
                            cw_raddr   = idx(sx, sy);
                            state_next = ST_READ;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cw_we    = 1'b1;
                cw_waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    if (gen_reg)
                    begin
                        lfsr_next_v = (seed_reg == '0) ? 16'd1 : seed_reg;
                        sp_next     = (AW+1)'(1);
                        state_next  = ST_CARVE;
                        carved_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CARVE:
            begin
                // write start cell visited and push it
                cw_we       = 1'b1;
                cw_wdata    = {1'b1, WALL_ALL};
                sk_we       = 1'b1;
                sk_waddr    = '0;
                state_next  = ST_TOP;
            end
            ST_TOP:
            begin
                // stack top read issued; cell walls read of top next
                if (sp_reg == '0)
                begin
                    px_next    = '0;
                    py_next    = '0;
                    gen_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_NREQ;
                    nd_next    = DIR_N;
                    opt_next   = '0;
                    carved_next = 1'b1;
                end
            end
            ST_NREQ:
            begin
                if (carved_reg)
                begin
                    cx_next     = XW'(32'(sk_rdata) % GRID_WIDTH);
                    cy_next     = YW'(32'(sk_rdata) / GRID_WIDTH);
                    carved_next = 1'b0;
                    cw_raddr    = sk_rdata;
                    state_next  = ST_NREQ;
                end
                else
                begin
                    cwall_next = (nd_reg == DIR_N) ? cw_rdata[3:0] : cwall_reg;
                    cw_raddr   = idx(nx, ny);
                    state_next = ST_NWAIT;
                end
            end
            ST_NWAIT:
            begin
                cw_raddr   = idx(nx, ny);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                opt_next[nd_reg] = nin && !cw_rdata[4];
                if (nd_reg == DIR_W)
                begin
                    state_next = ST_MOVE;
                    dsel_next  = 2'd0;
                end
                else
                begin
                    nd_next    = nd_reg + 1'b1;
                    state_next = ST_NREQ;
                end
                if (nd_reg == DIR_W)
                begin
                    carved_next = 1'b1;
                end
            end
            ST_MOVE:
            begin
                if (gen_reg)
                begin
                    // carve sub-steps: 0 decide/write current (or pop), 1-2 read neighbor, 3 write it and push
                    case (dsel_reg)
                        2'd0:
                        begin
                            if (opt_reg == '0)
                            begin
                                sp_next    = sp_reg - 1'b1;
                                sk_raddr   = AW'(sp_reg - 2'd2);
                                state_next = ST_TOP;
                            end
                            else
                            begin
                                lfsr_next_v = lv;
                                nd_next     = pick;
                                cw_we       = 1'b1;
                                cw_wdata    = {1'b1, cwall_reg & ~wall_here(pick)};
                                cw_raddr    = 'x;
                                dsel_next   = 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            cw_raddr  = idx(nx, ny);
                            dsel_next = 2'd2;
                        end
                        2'd2:
                        begin
                            cw_raddr  = idx(nx, ny);
                            dsel_next = 2'd3;
                        end
                        default:
                        begin
                            cw_we    = 1'b1;
                            cw_waddr = idx(nx, ny);
                            cw_wdata = {1'b1, cw_rdata[3:0] & ~wall_there(nd_reg)};
                            if (32'(sp_reg) < DEPTH)
                            begin
                                sk_we    = 1'b1;
                                sk_wdata = idx(nx, ny);
                                sk_raddr = sp_reg[AW-1:0];
                                sp_next  = sp_reg + 1'b1;
                            end
                            else
                            begin
                                sk_raddr = AW'(sp_reg - 1'b1);
                            end
                            state_next = ST_TOP;
                        end
                    endcase
                end
                else
                begin
                    // player move; walls of the player cell read here
                    cw_raddr = idx(px_reg, py_reg);
                    cx_next = px_reg;
                    cy_next = py_reg;
                    nd_next = req_reg.direction;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                out_next = '0;
                if (req_reg.op == OP_READ)
                begin
                    out_next.walls = cw_rdata[3:0];
                end
                else
                begin
                    if (nin && ((cw_rdata[3:0] & wall_here(nd_reg)) == '0))
                    begin
                        px_next        = nx;
                        py_next        = ny;
                        out_next.moved = 1'b1;
                        if (mc_reg != 16'hFFFF)
                        begin
                            mc_next = mc_reg + 1'b1;
                        end
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (req_reg.op != OP_READ && !(req_reg.op == OP_MOVE))
                begin
                    out_next = '0;
                end
                out_next.player_col = px_reg;
                out_next.player_row = py_reg;
                out_next.move_total = mc_reg;
                out_next.at_goal    = (32'(px_reg) == GRID_WIDTH - 1)
                                   && (32'(py_reg) == GRID_HEIGHT - 1);
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            seed_reg   <= 16'd1;
            lfsr_reg   <= 16'd1;
            sp_reg     <= '0;
            clr_reg    <= '0;
            gen_reg    <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            mc_reg     <= '0;
            ov_reg     <= 1'b0;
            carved_reg <= 1'b0;
            dsel_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            lfsr_reg   <= lfsr_next_v;
            sp_reg     <= sp_next;
            clr_reg    <= clr_next;
            gen_reg    <= gen_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            mc_reg     <= mc_next;
            ov_reg     <= ov_next;
            carved_reg <= carved_next;
            dsel_reg   <= dsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        nd_reg    <= nd_next;
        opt_reg   <= opt_next;
        cwall_reg <= cwall_next;
        out_reg   <= out_next;
    end

    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    a_one_txn: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
        else $error("response dropped under stall");
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= DEPTH)
        else $error("stack overflow");
    a_moved_only_move: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.moved) |-> (rsp.data.walls == '0))
        else $error("moved set on a read");
endmodule
